// ===== sv/pbfs_pkg.sv =====
package pbfs_pkg;

    // Fixed widths of the store word and of the item fields.
    localparam int WORD_BITS = 64;
    localparam int POS_W     = 16;
    localparam int FB_W      = 7;
    localparam int OFF_W     = 6;
    localparam int IDX_W     = POS_W - OFF_W;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_GET    = 1'b1;

    // Status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic                 command;
        logic [POS_W-1:0]     bit_pos;
        logic [FB_W-1:0]      field_bits;
        logic [WORD_BITS-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_value;
        logic                 status;
    } out_item_t;

    // An accepted access, decoded: width already saturated to a word.
    typedef struct packed {
        logic                 command;
        logic                 active;
        logic                 err;
        logic [OFF_W-1:0]     off;
        logic [FB_W-1:0]      width;
        logic [WORD_BITS-1:0] value;
    } op_t;

    // Write-back requests for the word holding the field's MSB (hi) and the next one (lo).
    typedef struct packed {
        logic hi;
        logic lo;
    } wr_t;

endpackage

// ===== sv/pbfs_in_if.sv =====
interface pbfs_in_if;

    logic                valid;
    logic                ready;
    pbfs_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== sv/pbfs_out_if.sv =====
interface pbfs_out_if;

    logic                valid;
    logic                ready;
    pbfs_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== sv/packed_bit_field_store.sv =====
// Channel  Role    Handshake       Payload
// req      sink    valid / ready   command, bit_pos, field_bits, value
// resp     source  valid / ready   read_value, status
//
// Items are handled one at a time: the accepting edge issues the read of both
// neighbouring words, and the following edge writes them back and loads the
// result register. The registered read of the word banks sets this split.
// After reset a clearing pass over ceil(STORE_WORDS / 2) rows zeroes both banks;
// req.ready stays low until it is done. A waiting result does not block the next
// item as long as resp.ready is high at the accepting edge.

module packed_bit_field_store #(
    parameter int STORE_WORDS = 1024
) (
    input logic             clk,
    input logic             rst_n,
    pbfs_in_if.sink         req,
    pbfs_out_if.source      resp
);

    localparam int WB   = pbfs_pkg::WORD_BITS;
    // Words are interleaved over two banks: even word numbers in one, odd in the
    // other, so the two words a field may straddle are always in different banks.
    localparam int HALF = (STORE_WORDS + 1) / 2;
    localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1;
    localparam logic [31:0] TOTAL_BITS = 32'(STORE_WORDS) * 32'(WB);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_MODIFY = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [AW-1:0]          clr_cnt_reg;
    logic [AW-1:0]          clr_cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    pbfs_pkg::out_item_t    out_data_reg;
    pbfs_pkg::op_t          op_reg;
    logic                   odd_reg;
    logic [AW-1:0]          even_addr_reg;
    logic [AW-1:0]          odd_addr_reg;

    logic                   accept;
    logic                   clearing;
    logic                   modifying;
    pbfs_pkg::op_t          op_in;
    logic [pbfs_pkg::FB_W-1:0] width_sat;
    logic [pbfs_pkg::POS_W:0]  pos_end;
    logic [15:0]            half_idx;
    logic [AW-1:0]          even_rd_addr;
    logic [AW-1:0]          odd_rd_addr;

    logic [WB-1:0]          even_rd_data;
    logic [WB-1:0]          odd_rd_data;
    logic [WB-1:0]          word_hi;
    logic [WB-1:0]          word_lo;
    logic [WB-1:0]          read_value;
    logic [WB-1:0]          new_hi;
    logic [WB-1:0]          new_lo;
    pbfs_pkg::wr_t          wr;

    logic                   even_wr_en;
    logic                   odd_wr_en;
    logic [AW-1:0]          even_wr_addr;
    logic [AW-1:0]          odd_wr_addr;
    logic [WB-1:0]          even_wr_data;
    logic [WB-1:0]          odd_wr_data;

    assign clearing  = (state_reg == ST_CLEAR);
    assign modifying = (state_reg == ST_MODIFY);

    // An item is taken only when no other is in flight and the result
    // register is free or is being emptied at the same edge.
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || resp.ready);
    assign accept    = req.valid && req.ready;

    // Decode the incoming item: saturate the width and check the store's end.
    // A zero-width access still gets the range check but touches nothing.
    always_comb
    begin
        if (req.data.field_bits > pbfs_pkg::FB_W'(WB))
        begin
            width_sat = pbfs_pkg::FB_W'(WB);
        end
        else
        begin
            width_sat = req.data.field_bits;
        end
        pos_end       = {1'b0, req.data.bit_pos} + (pbfs_pkg::POS_W + 1)'(width_sat);
        op_in.command = req.data.command;
        op_in.err     = 32'(pos_end) > TOTAL_BITS;
        op_in.active  = !op_in.err && (width_sat != '0);
        op_in.off     = req.data.bit_pos[pbfs_pkg::OFF_W-1:0];
        op_in.width   = width_sat;
        op_in.value   = req.data.value;

        // Word i = bit_pos / 64 lives at i / 2 in its bank; when i is odd the
        // next word sits one row further down in the even bank.
        half_idx     = 16'(req.data.bit_pos[pbfs_pkg::POS_W-1:pbfs_pkg::OFF_W+1]);
        odd_rd_addr  = half_idx[AW-1:0];
        even_rd_addr = AW'(half_idx + 16'(req.data.bit_pos[pbfs_pkg::OFF_W]));
    end

    pbfs_bank #(
        .DEPTH (HALF),
        .AW    (AW)
    ) u_even_bank (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (even_rd_addr),
        .rd_data (even_rd_data),
        .wr_en   (even_wr_en),
        .wr_addr (even_wr_addr),
        .wr_data (even_wr_data)
    );

    pbfs_bank #(
        .DEPTH (HALF),
        .AW    (AW)
    ) u_odd_bank (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (odd_rd_addr),
        .rd_data (odd_rd_data),
        .wr_en   (odd_wr_en),
        .wr_addr (odd_wr_addr),
        .wr_data (odd_wr_data)
    );

    // Put the words in field order: hi holds the field's MSB.
    assign word_hi = odd_reg ? odd_rd_data : even_rd_data;
    assign word_lo = odd_reg ? even_rd_data : odd_rd_data;

    pbfs_field u_field (
        .op         (op_reg),
        .word_hi    (word_hi),
        .word_lo    (word_lo),
        .read_value (read_value),
        .new_hi     (new_hi),
        .new_lo     (new_lo),
        .wr         (wr)
    );

    // Write ports: the clearing pass has them after reset, the modify cycle
    // afterwards. Only one item is ever in flight, so a read never meets a
    // pending write to the same word.
    always_comb
    begin
        if (clearing)
        begin
            even_wr_en   = 1'b1;
            odd_wr_en    = 1'b1;
            even_wr_addr = clr_cnt_reg;
            odd_wr_addr  = clr_cnt_reg;
            even_wr_data = '0;
            odd_wr_data  = '0;
        end
        else
        begin
            even_wr_en   = modifying && (odd_reg ? wr.lo : wr.hi);
            odd_wr_en    = modifying && (odd_reg ? wr.hi : wr.lo);
            even_wr_addr = even_addr_reg;
            odd_wr_addr  = odd_addr_reg;
            even_wr_data = odd_reg ? new_lo : new_hi;
            odd_wr_data  = odd_reg ? new_hi : new_lo;
        end
    end

    // Sequencer: clearing pass, then idle / modify alternating per item.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(HALF - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (modifying)
        begin
            out_valid_next = 1'b1;
        end
        else if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: the item in flight and the result waiting.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op_in;
            odd_reg       <= req.data.bit_pos[pbfs_pkg::OFF_W];
            even_addr_reg <= even_rd_addr;
            odd_addr_reg  <= odd_rd_addr;
        end
        if (modifying)
        begin
            out_data_reg.read_value <= read_value;
            out_data_reg.status     <= op_reg.err ? pbfs_pkg::STATUS_RANGE
                                                  : pbfs_pkg::STATUS_OK;
        end
    end

    assign resp.valid = out_valid_reg;
    assign resp.data  = out_data_reg;

    // An accepted item goes straight into its modify cycle.
    a_accept_modify: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> modifying)
        else $error("accepted item did not enter the modify cycle");

    // Every modify cycle leaves a result waiting.
    a_modify_result: assert property (@(posedge clk) disable iff (!rst_n)
        modifying |=> resp.valid)
        else $error("modify cycle produced no result");

    // Field write-back happens only in a modify cycle.
    a_write_in_modify: assert property (@(posedge clk) disable iff (!rst_n)
        (!clearing && (even_wr_en || odd_wr_en)) |-> modifying)
        else $error("bank written outside a modify cycle");

    // No item is taken while the banks are being cleared.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready)
        else $error("item accepted during the clearing pass");

    // A rejected access never returns data.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (resp.valid && resp.data.status == pbfs_pkg::STATUS_RANGE)
            |-> (resp.data.read_value == '0))
        else $error("out-of-range access returned data");

endmodule

// ===== sv/pbfs_bank.sv =====
module pbfs_bank #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [pbfs_pkg::WORD_BITS-1:0] rd_data,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [pbfs_pkg::WORD_BITS-1:0] wr_data
);

    logic [pbfs_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [pbfs_pkg::WORD_BITS-1:0] rd_data_reg;

    // Synchronous RAM with a registered read; read data is the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/pbfs_field.sv =====
module pbfs_field (
    input  pbfs_pkg::op_t                  op,
    input  logic [pbfs_pkg::WORD_BITS-1:0] word_hi,
    input  logic [pbfs_pkg::WORD_BITS-1:0] word_lo,
    output logic [pbfs_pkg::WORD_BITS-1:0] read_value,
    output logic [pbfs_pkg::WORD_BITS-1:0] new_hi,
    output logic [pbfs_pkg::WORD_BITS-1:0] new_lo,
    output pbfs_pkg::wr_t                  wr
);

    localparam int WB = pbfs_pkg::WORD_BITS;

    logic [2*WB-1:0]            window;
    logic [2*WB-1:0]            aligned;
    logic [2*WB-1:0]            placed;
    logic [WB-1:0]              mask;
    logic [WB-1:0]              masked;
    logic [pbfs_pkg::FB_W-1:0]  rshift;
    logic [pbfs_pkg::FB_W-1:0]  field_end;

    always_comb
    begin
        // Two neighbouring words form one window, MSB first.
        window    = {word_hi, word_lo};
        rshift    = pbfs_pkg::FB_W'(WB) - op.width;
        field_end = pbfs_pkg::FB_W'(op.off) + op.width;

        // Extraction: bring the field's MSB to the top, then right align it.
        aligned = window << op.off;
        if (op.active && op.command == pbfs_pkg::CMD_GET)
        begin
            read_value = aligned[2*WB-1:WB] >> rshift;
        end
        else
        begin
            read_value = '0;
        end

        // Insertion: discard value bits above the width, then place and OR in.
        if (op.width >= pbfs_pkg::FB_W'(WB))
        begin
            mask = '1;
        end
        else
        begin
            mask = (WB'(1) << op.width) - WB'(1);
        end
        masked = op.value & mask;
        // The field's MSB goes to the top of the window first, then down to its offset.
        placed = ({masked, {WB{1'b0}}} << rshift) >> op.off;
        new_hi = word_hi | placed[2*WB-1:WB];
        new_lo = word_lo | placed[WB-1:0];

        wr.hi = op.active && op.command == pbfs_pkg::CMD_INSERT;
        wr.lo = wr.hi && (field_end > pbfs_pkg::FB_W'(WB));
    end

endmodule
